FILE: rtl/button_click_hold_detector_macros.svh
// ----------------------------------------------------------------------------
// Button click / hold detector: assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, held off during reset
`define BCHD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bchd: implication check failed");

// Next-cycle implication, held off during reset
`define BCHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bchd: next-cycle check failed");

`else

`define BCHD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BCHD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/bchd_pkg.sv
// ----------------------------------------------------------------------------
// Button click / hold detector package
// Phase and event codes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package bchd_pkg;

    // Widths
    localparam int TIME_W  = 16;
    localparam int COUNT_W = 8;
    localparam int PHASE_W = 3;
    localparam int EVENT_W = 3;
    localparam int CFG_IDX_W = 2;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PDEB     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PRESSING = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HOLDING  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RDEB     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_WAITING  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_PSUSP    = 3'd6;
    localparam logic [PHASE_W-1:0] PH_PDSUSP   = 3'd7;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_PRESSED  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_CLICKED  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_HOLD     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_RELEASED = 3'd4;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT  = 3'd5;

    // Request kinds
    localparam logic REQ_POLL    = 1'b0;
    localparam logic REQ_SUSPEND = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    // Register reset values
    localparam logic [TIME_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [TIME_W-1:0] HOLD_RST     = 16'd500;
    localparam logic [TIME_W-1:0] TIMEOUT_RST  = 16'd300;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Timing configuration as seen by the step logic
    typedef struct packed {
        logic [TIME_W-1:0] debounce_time;
        logic [TIME_W-1:0] hold_time;
        logic [TIME_W-1:0] click_timeout;
    } cfg_t;

    // Detector state
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [TIME_W-1:0]  mark_time;
        logic [COUNT_W-1:0] click_count;
    } state_t;

    // One registered request
    typedef struct packed {
        logic              req_type;
        logic              contact_level;
        logic              latched_press;
        logic [TIME_W-1:0] now_ms;
    } req_t;

    // One result
    typedef struct packed {
        logic [EVENT_W-1:0] event_code;
        logic [COUNT_W-1:0] click_total;
        logic               is_busy;
        logic               is_holding;
        logic               is_waiting;
        logic               is_pressed;
    } res_t;

endpackage

FILE: rtl/bchd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Button click / hold detector: configuration registers
// Debounce, hold and click timeout registers behind a valid/ready write port.
// ----------------------------------------------------------------------------
module bchd_cfg_regs
    import bchd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    logic [TIME_W-1:0] debounce_reg;
    logic [TIME_W-1:0] hold_reg;
    logic [TIME_W-1:0] timeout_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register write; an unused index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            hold_reg     <= HOLD_RST;
            timeout_reg  <= TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_data;
                CFG_HOLD:     hold_reg     <= cfg_data;
                CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign cfg.debounce_time = debounce_reg;
    assign cfg.hold_time     = hold_reg;
    assign cfg.click_timeout = timeout_reg;

endmodule

FILE: rtl/bchd_step.sv
// ----------------------------------------------------------------------------
// Button click / hold detector: step logic
// Next phase, start mark, click count and event for one request.
// ----------------------------------------------------------------------------
module bchd_step
    import bchd_pkg::*;
(
    input  cfg_t   cfg,
    input  state_t cur,
    input  req_t   req,
    output state_t nxt,
    output res_t   res
);

    logic              on;
    logic [TIME_W-1:0] elapsed;
    logic              deb_done;
    logic              hold_done;
    logic              wait_done;
    logic [EVENT_W-1:0] ev;

    // Elapsed time wraps at 2^16
    assign on        = req.contact_level | req.latched_press;
    assign elapsed   = req.now_ms - cur.mark_time;
    assign deb_done  = (elapsed >= cfg.debounce_time);
    assign hold_done = (elapsed >= cfg.hold_time);
    assign wait_done = (elapsed >= cfg.click_timeout);

    // Phase machine
    always_comb
    begin
        nxt = cur;
        ev  = EV_NONE;
        if (req.req_type == REQ_SUSPEND)
        begin
            if (cur.phase inside {PH_PRESSING, PH_HOLDING})
                nxt.phase = PH_PSUSP;
            else if (cur.phase == PH_PDEB)
                nxt.phase = PH_PDSUSP;
        end
        else
        begin
            case (cur.phase)
                PH_IDLE:
                begin
                    if (on)
                    begin
                        nxt.mark_time = req.now_ms;
                        nxt.phase     = PH_PDEB;
                        ev            = EV_PRESSED;
                    end
                end
                PH_PDEB:
                begin
                    if (deb_done)
                        nxt.phase = PH_PRESSING;
                end
                PH_PRESSING:
                begin
                    if (!on)
                    begin
                        if (cur.click_count != COUNT_MAX)
                            nxt.click_count = cur.click_count + COUNT_W'(1);
                        nxt.mark_time = req.now_ms;
                        nxt.phase     = PH_RDEB;
                        ev            = EV_CLICKED;
                    end
                    else if (hold_done)
                    begin
                        nxt.phase = PH_HOLDING;
                        ev        = EV_HOLD;
                    end
                end
                PH_HOLDING:
                begin
                    if (!on)
                    begin
                        nxt.click_count = '0;
                        nxt.mark_time   = req.now_ms;
                        nxt.phase       = PH_RDEB;
                        ev              = EV_RELEASED;
                    end
                end
                PH_RDEB:
                begin
                    if (deb_done)
                    begin
                        nxt.mark_time = req.now_ms;
                        if (on)
                        begin
                            nxt.phase = PH_PDEB;
                            ev        = EV_PRESSED;
                        end
                        else
                            nxt.phase = PH_WAITING;
                    end
                end
                PH_WAITING:
                begin
                    if (on)
                    begin
                        nxt.mark_time = req.now_ms;
                        nxt.phase     = PH_PDEB;
                        ev            = EV_PRESSED;
                    end
                    else if (wait_done)
                    begin
                        nxt.click_count = '0;
                        nxt.phase       = PH_IDLE;
                        ev              = EV_TIMEOUT;
                    end
                end
                PH_PSUSP:
                begin
                    if (!on)
                    begin
                        nxt.mark_time = req.now_ms;
                        nxt.phase     = PH_RDEB;
                        ev            = EV_RELEASED;
                    end
                end
                PH_PDSUSP:
                begin
                    if (deb_done)
                    begin
                        if (on)
                            nxt.phase = PH_PSUSP;
                        else
                        begin
                            nxt.mark_time = req.now_ms;
                            nxt.phase     = PH_RDEB;
                            ev            = EV_RELEASED;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result fields from the updated state
    always_comb
    begin
        res.event_code  = ev;
        res.click_total = nxt.click_count;
        res.is_busy     = (nxt.phase != PH_IDLE);
        res.is_holding  = (nxt.phase == PH_HOLDING);
        res.is_waiting  = (nxt.phase == PH_WAITING);
        res.is_pressed  = (nxt.phase inside {PH_PRESSING, PH_PDEB, PH_PSUSP, PH_HOLDING});
    end

endmodule

FILE: rtl/button_click_hold_detector.sv
// Flow: an accepted request is held in the input register, and its
// result is loaded into the result register once the result slot frees.
// Throughput: one request per cycle when results are not stalled; the state
// update is one 16-bit subtract and three compares between the two registers.
// Reset: rst_n is asynchronous, active low; clears both stages, the phase,
// start mark and click count, and loads the timing registers' defaults.
// ----------------------------------------------------------------------------
// Button click / hold detector
// Debounces a button, counts clicks, detects holds and click-sequence timeout.
// ----------------------------------------------------------------------------
`include "button_click_hold_detector_macros.svh"

module button_click_hold_detector
    import bchd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic                 req_type,
    input  logic                 contact_level,
    input  logic                 latched_press,
    input  logic [TIME_W-1:0]    now_ms,
    // result channel
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [EVENT_W-1:0]   event_code,
    output logic [COUNT_W-1:0]   click_total,
    output logic                 is_busy,
    output logic                 is_holding,
    output logic                 is_waiting,
    output logic                 is_pressed,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data
);

    cfg_t   cfg;
    state_t state_reg;
    state_t state_next;
    req_t   req_reg;
    res_t   res_reg;
    res_t   res_next;
    logic   req_full_reg;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   req_take;
    logic   advance;

    bchd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bchd_step u_step (
        .cfg (cfg),
        .cur (state_reg),
        .req (req_reg),
        .nxt (state_next),
        .res (res_next)
    );

    // Handshake: the held request moves on whenever the result slot frees
    assign advance   = req_full_reg && (!res_valid_reg || !res_stall);
    assign req_stall = req_full_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    always_comb
    begin
        if (advance)
            res_valid_next = 1'b1;
        else if (res_stall)
            res_valid_next = res_valid_reg;
        else
            res_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_full_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (req_take)
                req_full_reg <= 1'b1;
            else if (advance)
                req_full_reg <= 1'b0;
            res_valid_reg <= res_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Input request register
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg.req_type      <= req_type;
            req_reg.contact_level <= contact_level;
            req_reg.latched_press <= latched_press;
            req_reg.now_ms        <= now_ms;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign res_valid   = res_valid_reg;
    assign event_code  = res_reg.event_code;
    assign click_total = res_reg.click_total;
    assign is_busy     = res_reg.is_busy;
    assign is_holding  = res_reg.is_holding;
    assign is_waiting  = res_reg.is_waiting;
    assign is_pressed  = res_reg.is_pressed;

    // Checks
    `BCHD_ASSERT_IMPLY(a_idle_no_clicks, clk, rst_n,
        state_reg.phase == PH_IDLE, state_reg.click_count == '0)
    `BCHD_ASSERT_IMPLY(a_timeout_idle, clk, rst_n,
        res_valid && event_code == EV_TIMEOUT, !is_busy && click_total == '0)
    `BCHD_ASSERT_IMPLY(a_click_released, clk, rst_n,
        res_valid && event_code == EV_CLICKED, is_busy && !is_pressed && !is_waiting)
    `BCHD_ASSERT_NEXT(a_advance_gives_result, clk, rst_n,
        advance, res_valid)

endmodule
